FILE: hdl/bdq_pkg.sv
// bdq_pkg: sizes, opcode and status codes for the bounded deque with search
// no dependencies; used by the channel interfaces and the top level
`default_nettype none

package bdq_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int POS_W    = 5;
    localparam int OP_W     = 3;
    localparam int ST_W     = 2;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_SEARCH     = 3'd4,
        OP_DUMP       = 3'd5
    } t_opcode;

    typedef enum logic [ST_W-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

endpackage

`default_nettype wire

FILE: hdl/bdq_if.sv
// bdq_req_if / bdq_rsp_if: valid-ready channels for requests and results
// depends on bdq_pkg for field widths
`default_nettype none

interface bdq_req_if
    import bdq_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          opcode;
    logic signed [DATA_W-1:0] value_in;

    modport source (output valid, output opcode, output value_in, input ready);
    modport sink   (input valid, input opcode, input value_in, output ready);
endinterface

interface bdq_rsp_if
    import bdq_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [ST_W-1:0]          status;
    logic signed [DATA_W-1:0] value_out;
    logic [POS_W-1:0]         position;
    logic                     last;

    modport source (output valid, output status, output value_out, output position,
                    output last, input ready);
    modport sink   (input valid, input status, input value_out, input position,
                    input last, output ready);
endinterface

`default_nettype wire

FILE: hdl/bounded_deque_with_search.sv
// bounded_deque_with_search: ring deque of 32-bit words in one synchronous memory
// depends on bdq_pkg and the channel interfaces in bdq_if.sv
`default_nettype none

// Bounded deque of CAPACITY signed 32-bit words kept as a ring in a single
// one-port-read, one-port-write memory with registered read data. A request
// item carries an opcode: push front, push back, pop front, pop back, search
// or dump; opcodes 6 and 7 are taken and dropped with no result. Pushes and
// every empty or full answer produce their single result item in the cycle
// after acceptance. Pops read the memory into the read data register and then
// move the word into the output register. Search and dump walk the stored
// words from front to back, one memory read per cycle while the result channel
// does not stall: a dump emits entry_count result items (last set on the final
// one), a search finishes on the first match or after all entry_count words.
// A stalled result channel simply holds the walk. One request is worked on at
// a time; a new one is taken only once the previous one has put its final
// result into the output register and that register is empty or being emptied
// in the same cycle, so a result item that waits on the result channel also
// holds off the next request.
// No clearing pass is needed after reset: only occupied slots are ever read.
module bounded_deque_with_search
    import bdq_pkg::*;
(
    input  wire       i_clk,
    input  wire       i_rst_n,
    bdq_req_if.sink   i_req,
    bdq_rsp_if.source o_rsp
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_WALK
    } t_state;

    // ring storage
    logic [DATA_W-1:0] mem [CAPACITY];

    t_state            r_state, n_state;
    logic [IDX_W-1:0]  r_front, n_front;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_idx, n_idx;       // next walk offset to read
    logic [CNT_W-1:0]  r_tag, n_tag;       // walk offset of the word in r_rd_data
    logic              r_dv, n_dv;         // r_rd_data holds an unconsumed walk word
    logic              r_dump, n_dump;     // walk is a dump, else a search
    logic [DATA_W-1:0] r_key, n_key;
    logic [DATA_W-1:0] r_rd_data;

    logic              r_out_valid, n_out_valid;
    logic [ST_W-1:0]   r_status, n_status;
    logic [DATA_W-1:0] r_value, n_value;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic              r_last, n_last;

    logic              w_we, w_re, w_acc, w_out_free, w_adv, w_done, w_full;
    logic [IDX_W-1:0]  w_waddr, w_raddr;
    logic [CNT_W-1:0]  w_tail_tag;

    // ring slot for an offset from the front; the sum stays below twice the capacity
    function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] front,
                                                 input logic [CNT_W-1:0] off);
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(front) + (CNT_W + 1)'(off);
        if (sum >= (CNT_W + 1)'(CAPACITY)) begin
            sum = sum - (CNT_W + 1)'(CAPACITY);
        end
        return sum[IDX_W-1:0];
    endfunction

    assign w_out_free  = !r_out_valid || o_rsp.ready;
    assign i_req.ready = (r_state == S_IDLE) && w_out_free;
    assign w_acc       = i_req.valid && i_req.ready;
    assign w_full      = (r_count == CNT_W'(CAPACITY));
    assign w_tail_tag  = r_count - 1'b1;
    assign w_adv       = !r_dv || w_out_free;

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.status    = r_status;
    assign o_rsp.value_out = r_value;
    assign o_rsp.position  = r_pos;
    assign o_rsp.last      = r_last;

    always_comb begin
        n_state     = r_state;
        n_front     = r_front;
        n_count     = r_count;
        n_idx       = r_idx;
        n_tag       = r_tag;
        n_dv        = r_dv;
        n_dump      = r_dump;
        n_key       = r_key;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_status    = r_status;
        n_value     = r_value;
        n_pos       = r_pos;
        n_last      = r_last;
        w_we        = 1'b0;
        w_waddr     = r_front;
        w_re        = 1'b0;
        w_raddr     = r_front;
        w_done      = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    // default answer: ok, single result
                    n_status = ST_OK;
                    n_value  = '0;
                    n_pos    = '0;
                    n_last   = 1'b1;
                    unique case (i_req.opcode) inside
                        OP_PUSH_FRONT, OP_PUSH_BACK: begin
                            n_out_valid = 1'b1;
                            if (w_full) begin
                                n_status = ST_FULL;
                            end else begin
                                w_we    = 1'b1;
                                n_count = r_count + 1'b1;
                                if (i_req.opcode == OP_PUSH_FRONT) begin
                                    w_waddr = (r_front == '0) ? IDX_W'(CAPACITY - 1)
                                                              : r_front - 1'b1;
                                    n_front = w_waddr;
                                end else begin
                                    w_waddr = slot_of(r_front, r_count);
                                end
                            end
                        end
                        OP_POP_FRONT, OP_POP_BACK: begin
                            if (r_count == '0) begin
                                n_out_valid = 1'b1;
                                n_status    = ST_EMPTY;
                            end else begin
                                w_re    = 1'b1;
                                n_count = r_count - 1'b1;
                                n_state = S_POP;
                                if (i_req.opcode == OP_POP_FRONT) begin
                                    w_raddr = r_front;
                                    n_front = (r_front == IDX_W'(CAPACITY - 1)) ? '0
                                                                                : r_front + 1'b1;
                                end else begin
                                    w_raddr = slot_of(r_front, w_tail_tag);
                                end
                            end
                        end
                        OP_SEARCH, OP_DUMP: begin
                            if (r_count == '0) begin
                                n_out_valid = 1'b1;
                                n_status    = ST_EMPTY;
                            end else begin
                                n_state = S_WALK;
                                n_idx   = '0;
                                n_dv    = 1'b0;
                                n_dump  = (i_req.opcode == OP_DUMP);
                                n_key   = i_req.value_in;
                            end
                        end
                        default: begin
                            // unused opcode: dropped, no result
                        end
                    endcase
                end
            end

            S_POP: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_value     = r_rd_data;
                    n_state     = S_IDLE;
                end
            end

            S_WALK: begin
                if (w_adv) begin
                    // consume the walk word held in r_rd_data
                    if (r_dv) begin
                        if (r_dump) begin
                            n_out_valid = 1'b1;
                            n_status    = ST_OK;
                            n_value     = r_rd_data;
                            n_pos       = '0;
                            n_last      = (r_tag == w_tail_tag);
                            w_done      = (r_tag == w_tail_tag);
                        end else if (r_rd_data == r_key) begin
                            n_out_valid = 1'b1;
                            n_status    = ST_OK;
                            n_value     = '0;
                            n_pos       = POS_W'(r_tag + 1'b1);
                            n_last      = 1'b1;
                            w_done      = 1'b1;
                        end else if (r_tag == w_tail_tag) begin
                            n_out_valid = 1'b1;
                            n_status    = ST_NOTFOUND;
                            n_value     = '0;
                            n_pos       = '0;
                            n_last      = 1'b1;
                            w_done      = 1'b1;
                        end
                    end
                    // issue the next read unless the walk ends here
                    if (!w_done && (r_idx < r_count)) begin
                        w_re    = 1'b1;
                        w_raddr = slot_of(r_front, r_idx);
                        n_tag   = r_idx;
                        n_idx   = r_idx + 1'b1;
                        n_dv    = 1'b1;
                    end else begin
                        n_dv = 1'b0;
                    end
                    if (w_done) begin
                        n_state = S_IDLE;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= i_req.value_in;
        end
        if (w_re) begin
            r_rd_data <= mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front     <= '0;
            r_count     <= '0;
            r_idx       <= '0;
            r_dv        <= 1'b0;
            r_dump      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front     <= n_front;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_dv        <= n_dv;
            r_dump      <= n_dump;
            r_out_valid <= n_out_valid;
        end
        r_tag    <= n_tag;
        r_key    <= n_key;
        r_status <= n_status;
        r_value  <= n_value;
        r_pos    <= n_pos;
        r_last   <= n_last;
    end

    // occupancy never passes the ring size
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // the ring is only written by an accepted push
    a_write_on_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (w_acc && !w_full &&
                  (i_req.opcode == OP_PUSH_FRONT || i_req.opcode == OP_PUSH_BACK)))
        else $error("memory written outside a push");

    // a successful push grows the deque by one
    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && !w_full &&
         (i_req.opcode == OP_PUSH_FRONT || i_req.opcode == OP_PUSH_BACK))
        |=> r_count == CNT_W'($past(r_count) + 1'b1))
        else $error("push did not grow the deque");

    // a walk never reads past the occupied entries
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_idx <= r_count))
        else $error("walk offset beyond occupied entries");

endmodule

`default_nettype wire
